// ===== src/name_text_to_display_char_top_defines.svh =====
// Assertion macros shared by the name-to-display converter RTL.
`ifndef NAME_TEXT_TO_DISPLAY_CHAR_TOP_DEFINES_SVH
`define NAME_TEXT_TO_DISPLAY_CHAR_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define NTDC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("ntdc assertion failed");
`define NTDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ntdc assertion failed");
`else
`define NTDC_ASSERT(lbl, clk, rst_n, prop)
`define NTDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/ntdc_pkg.sv =====
// Types, codes and character mapping functions of the name-to-display converter.
package ntdc_pkg;

	localparam logic [1:0] FMT_TEXT8 = 2'd0;
	localparam logic [1:0] FMT_UTF16 = 2'd1;
	localparam logic [1:0] FMT_UTF8  = 2'd2;

	localparam logic [1:0] REG_NAME_FORMAT     = 2'd0;
	localparam logic [1:0] REG_CYRILLIC_ENABLE = 2'd1;
	localparam logic [1:0] REG_REPLACE_CHAR    = 2'd2;

	localparam logic [1:0]  RST_NAME_FORMAT     = FMT_TEXT8;
	localparam logic        RST_CYRILLIC_ENABLE = 1'b1;
	localparam logic [7:0]  RST_REPLACE_CHAR    = 8'd45;

	localparam logic [15:0] UNIT_BOM    = 16'hFEFF;
	localparam logic [7:0]  CYR_BASE    = 8'hC0;
	localparam logic [7:0]  CYR_SPECIAL = 8'hE0;
	localparam logic [7:0]  CP_YO_UPPER = 8'hA8;
	localparam logic [7:0]  CP_YO_LOWER = 8'hB8;
	localparam logic [7:0]  SHOW_LOW    = 8'h20;
	localparam logic [7:0]  SHOW_HIGH   = 8'h7F;

	typedef struct packed {
		logic [1:0] name_format;
		logic       cyrillic_enable;
		logic [7:0] replace_char;
	} ntdc_cfg_t;

	typedef struct packed {
		logic [15:0] acc;
		logic [2:0]  rem;
		logic [7:0]  count;
		logic        ended;
	} ntdc_state_t;

	typedef struct packed {
		logic       char_valid;
		logic [7:0] out_char;
		logic       end_of_name;
		logic [7:0] name_length;
	} ntdc_res_t;

	function automatic logic [7:0] upcase(input logic [7:0] b);
		if (b >= 8'h61 && b <= 8'h7A) return b - 8'h20;
		return b;
	endfunction

	function automatic logic [7:0] byte_to_display(input logic [7:0] b, input logic cyr);
		if (cyr) begin
			if (b >= 8'hC0 && b <= 8'hDF) return b;
			if (b >= 8'hE0) return b - 8'h20;
			if (b == CP_YO_UPPER || b == CP_YO_LOWER) return CYR_SPECIAL;
		end
		return upcase(b);
	endfunction

	function automatic logic [7:0] code_to_display(input logic [15:0] u, input logic cyr,
			input logic [7:0] repl);
		logic [7:0]  hi;
		logic [7:0]  lo;
		logic [7:0]  r;
		logic [15:0] d;
		hi = u[15:8];
		lo = u[7:0];
		if (cyr) begin
			if (u >= 16'h0430 && u <= 16'h044F) begin
				d = u - 16'h0430;
				return CYR_BASE + d[7:0];
			end
			if (u >= 16'h0410 && u <= 16'h042F) begin
				d = u - 16'h0410;
				return CYR_BASE + d[7:0];
			end
			if (u == 16'h0451 || u == 16'h0401) return CYR_SPECIAL;
		end
		if (hi == 8'h00)
			r = (lo < SHOW_LOW || lo > SHOW_HIGH) ? repl : lo;
		else if (lo != 8'h00)
			r = repl;
		else
			r = (hi < SHOW_LOW || hi > SHOW_HIGH) ? repl : hi;
		return upcase(r);
	endfunction

endpackage

// ===== src/ntdc_decode.sv =====
// Decoder step: next name state and the result for one registered unit.
module ntdc_decode
	import ntdc_pkg::*;
#(
	parameter logic [7:0] LEN_LIMIT = 8'd255
) (
	input  ntdc_cfg_t   cfg,
	input  ntdc_state_t st,
	input  logic [15:0] unit,
	input  logic        last,
	output ntdc_state_t nxt,
	output logic        has_result,
	output ntdc_res_t   res
);

	logic [7:0]  b;
	logic [15:0] acc_shift;
	logic        e_go;
	logic        e_valid;
	logic [7:0]  e_ch;
	logic        e_end;
	logic [7:0]  count_new;
	ntdc_state_t work;

	assign b = unit[7:0];
	assign acc_shift = {st.acc[9:0], b[5:0]};

	always_comb begin
		work = st;
		e_go = 1'b0;
		e_valid = 1'b0;
		e_ch = 8'h00;
		e_end = 1'b0;
		if (!st.ended) begin
			if (cfg.name_format != FMT_UTF8) work.rem = 3'd0;
			unique case (cfg.name_format)
				FMT_TEXT8: begin
					e_go = 1'b1;
					if (b == 8'h00) begin
						e_end = 1'b1;
					end else begin
						e_valid = 1'b1;
						e_ch = byte_to_display(b, cfg.cyrillic_enable);
						e_end = last;
					end
				end
				FMT_UTF16: begin
					e_go = 1'b1;
					if (unit == 16'h0000 || unit == UNIT_BOM) begin
						e_end = 1'b1;
					end else begin
						e_valid = 1'b1;
						e_ch = code_to_display(unit, cfg.cyrillic_enable, cfg.replace_char);
						e_end = last;
					end
				end
				FMT_UTF8: begin
					if (st.rem != 3'd0) begin
						work.acc = acc_shift;
						work.rem = st.rem - 3'd1;
						if (st.rem == 3'd1) begin
							e_go = 1'b1;
							e_valid = 1'b1;
							e_ch = code_to_display(acc_shift, cfg.cyrillic_enable,
								cfg.replace_char);
							e_end = last;
						end else begin
							e_go = last;
							e_end = 1'b1;
						end
					end else if (b == 8'h00) begin
						e_go = 1'b1;
						e_end = 1'b1;
					end else if (!b[7]) begin
						e_go = 1'b1;
						e_valid = 1'b1;
						e_ch = code_to_display({9'd0, b[6:0]}, cfg.cyrillic_enable,
							cfg.replace_char);
						e_end = last;
					end else if (b[5:1] == 5'b11111) begin
						e_go = 1'b1;
						e_end = 1'b1;
					end else begin
						e_go = last;
						e_end = 1'b1;
						if (!b[5]) begin
							work.acc = {11'd0, b[4:0]};
							work.rem = 3'd1;
						end else if (!b[4]) begin
							work.acc = {12'd0, b[3:0]};
							work.rem = 3'd2;
						end else if (!b[3]) begin
							work.acc = {13'd0, b[2:0]};
							work.rem = 3'd3;
						end else if (!b[2]) begin
							work.acc = {14'd0, b[1:0]};
							work.rem = 3'd4;
						end else begin
							work.acc = {15'd0, b[0]};
							work.rem = 3'd5;
						end
					end
				end
				default: begin
					e_go = 1'b1;
					e_end = 1'b1;
				end
			endcase
		end
	end

	assign count_new = (e_go && e_valid && st.count < LEN_LIMIT) ? st.count + 8'd1 : st.count;

	always_comb begin
		nxt = work;
		nxt.count = count_new;
		if (e_go && e_end) nxt.ended = 1'b1;
		if (last) nxt = '0;
	end

	assign has_result = e_go;
	assign res.char_valid = e_valid;
	assign res.out_char = e_valid ? e_ch : 8'h00;
	assign res.end_of_name = e_end;
	assign res.name_length = count_new;

endmodule

// ===== src/name_text_to_display_char_top.sv =====
// An accepted unit is registered at the input, decoded, and its result registered at the output.
// Throughput: one unit per cycle unless stalled; the input register feeds one decode step per cycle.
// A unit after the end of a name, or a UTF-8 byte that leaves a sequence open and is not last, gives no result.
// Reset clears the decode state and both valid flags and loads the register defaults:
// eight-bit text, Cyrillic folding on and '-' as the replacement byte.
`include "name_text_to_display_char_top_defines.svh"

module name_text_to_display_char_top
	import ntdc_pkg::*;
#(
	parameter int unsigned NAME_MAX = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] code_unit,
	input  logic        last_unit,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        char_valid,
	output logic [7:0]  out_char,
	output logic        end_of_name,
	output logic [7:0]  name_length
);

	localparam int unsigned LEN_LIMIT_I = (NAME_MAX > 255) ? 255 : NAME_MAX;
	localparam logic [7:0]  LEN_LIMIT = 8'(LEN_LIMIT_I);

	ntdc_cfg_t   cfg_q;
	ntdc_state_t state_q;
	ntdc_state_t state_nxt;
	ntdc_res_t   res;
	ntdc_res_t   res_s2;
	logic        has_result;
	logic        valid_s1;
	logic [15:0] unit_s1;
	logic        last_s1;
	logic        valid_s2;
	logic        advance;

	assign advance = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.name_format <= RST_NAME_FORMAT;
			cfg_q.cyrillic_enable <= RST_CYRILLIC_ENABLE;
			cfg_q.replace_char <= RST_REPLACE_CHAR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NAME_FORMAT:     cfg_q.name_format <= cfg_wdata[1:0];
				REG_CYRILLIC_ENABLE: cfg_q.cyrillic_enable <= cfg_wdata[0];
				REG_REPLACE_CHAR:    cfg_q.replace_char <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q <= '0;
		end else begin
			if (!in_stall) valid_s1 <= in_valid;
			if (advance) begin
				valid_s2 <= has_result;
				state_q <= state_nxt;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			unit_s1 <= code_unit;
			last_s1 <= last_unit;
		end
		if (advance && has_result) res_s2 <= res;
	end

	ntdc_decode #(
		.LEN_LIMIT(LEN_LIMIT)
	) u_decode (
		.cfg       (cfg_q),
		.st        (state_q),
		.unit      (unit_s1),
		.last      (last_s1),
		.nxt       (state_nxt),
		.has_result(has_result),
		.res       (res)
	);

	assign out_valid = valid_s2;
	assign char_valid = res_s2.char_valid;
	assign out_char = res_s2.out_char;
	assign end_of_name = res_s2.end_of_name;
	assign name_length = res_s2.name_length;

	`NTDC_ASSERT(a_count_limit, clk, arst_n, state_q.count <= LEN_LIMIT)
	`NTDC_ASSERT(a_ended_no_seq, clk, arst_n, !state_q.ended || state_q.rem == 3'd0)
	`NTDC_ASSERT_NEXT(a_stall_holds_s1, clk, arst_n, in_stall, valid_s1)
	`NTDC_ASSERT_NEXT(a_no_result_empty, clk, arst_n, advance && !has_result, !valid_s2)

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the name-to-display character converter.
`timescale 1ns / 100ps

module testbench
	import ntdc_pkg::*;
;
	localparam int unsigned NAME_MAX_TB = 255;
	localparam int LEN_CAP = (NAME_MAX_TB > 255) ? 255 : NAME_MAX_TB;
	localparam logic [1:0] FMT_RESERVED = 2'd3;
	localparam logic [7:0] CHAR_STAR = 8'h2A;
	localparam logic [7:0] CHAR_DASH = 8'h2D;
	localparam int HOLD_CYCLES = 120;
	localparam int DRAIN_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 6;

	class char_scoreboard;
		logic [1:0]  fmt;
		logic        cyr;
		logic [7:0]  repl;
		logic [15:0] acc;
		logic [2:0]  left;
		logic [7:0]  count;
		logic        ended;
		int          len_cap;
		int          errors;
		int          seen;
		ntdc_res_t   due_chars[$];

		function new(int cap);
			len_cap = cap;
			errors = 0;
			seen = 0;
			fmt = RST_NAME_FORMAT;
			cyr = RST_CYRILLIC_ENABLE;
			repl = RST_REPLACE_CHAR;
			clear_name();
		endfunction

		function void clear_name();
			acc = '0;
			left = '0;
			count = '0;
			ended = 1'b0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [7:0] val);
			case (idx)
			REG_NAME_FORMAT: fmt = val[1:0];
			REG_CYRILLIC_ENABLE: cyr = val[0];
			REG_REPLACE_CHAR: repl = val;
			default: ;
			endcase
		endfunction

		function int pending();
			return due_chars.size();
		endfunction

		function logic [7:0] to_upper(logic [7:0] b);
			return (b >= "a" && b <= "z") ? b - 8'h20 : b;
		endfunction

		function logic [7:0] fold_byte(logic [7:0] b);
			if (cyr) begin
				if (b >= 8'hC0) return b[5] ? b - 8'h20 : b;
				if (b == CP_YO_UPPER || b == CP_YO_LOWER) return CYR_SPECIAL;
			end
			return to_upper(b);
		endfunction

		function logic [7:0] fold_code(logic [15:0] u);
			logic [15:0] d;
			logic [7:0]  r;
			if (cyr) begin
				if (u >= 16'h0410 && u <= 16'h044F) begin
					d = u - 16'h0410;
					return CYR_BASE + {3'b000, d[4:0]};
				end
				if (u == 16'h0401 || u == 16'h0451) return CYR_SPECIAL;
			end
			if (u[15:8] == 8'h00)
				r = (u[7:0] >= SHOW_LOW && u[7:0] <= SHOW_HIGH) ? u[7:0] : repl;
			else if (u[7:0] != 8'h00)
				r = repl;
			else
				r = (u[15:8] >= SHOW_LOW && u[15:8] <= SHOW_HIGH) ? u[15:8] : repl;
			return to_upper(r);
		endfunction

		function void push_char(logic valid, logic [7:0] ch, logic fin, logic last);
			ntdc_res_t r;
			if (valid && count < len_cap) count++;
			r.char_valid = valid;
			r.out_char = valid ? ch : 8'h00;
			r.end_of_name = fin;
			r.name_length = count;
			due_chars.push_back(r);
			if (last) clear_name();
			else if (fin) ended = 1'b1;
		endfunction

		function void utf8_byte(logic [7:0] b, logic last);
			if (left != 0) begin
				acc = {acc[9:0], b[5:0]};
				left = left - 3'd1;
				if (left == 0) push_char(1'b1, fold_code(acc), last, last);
				else if (last) push_char(1'b0, 8'h00, 1'b1, 1'b1);
				return;
			end
			if (b == 8'h00) begin
				push_char(1'b0, 8'h00, 1'b1, last);
				return;
			end
			if (!b[7]) begin
				push_char(1'b1, fold_code({9'd0, b[6:0]}), last, last);
				return;
			end
			casez (b)
			8'b1?0?_????: begin acc = {11'd0, b[4:0]}; left = 3'd1; end
			8'b1?10_????: begin acc = {12'd0, b[3:0]}; left = 3'd2; end
			8'b1?11_0???: begin acc = {13'd0, b[2:0]}; left = 3'd3; end
			8'b1?11_10??: begin acc = {14'd0, b[1:0]}; left = 3'd4; end
			8'b1?11_110?: begin acc = {15'd0, b[0]}; left = 3'd5; end
			default: begin
				push_char(1'b0, 8'h00, 1'b1, last);
				return;
			end
			endcase
			if (last) push_char(1'b0, 8'h00, 1'b1, 1'b1);
		endfunction

		function void decode_unit(logic [15:0] unit, logic last);
			if (ended) begin
				if (last) clear_name();
				return;
			end
			if (fmt != FMT_UTF8) left = '0;
			case (fmt)
			FMT_TEXT8:
				if (unit[7:0] == 8'h00) push_char(1'b0, 8'h00, 1'b1, last);
				else push_char(1'b1, fold_byte(unit[7:0]), last, last);
			FMT_UTF16:
				if (unit == 16'h0000 || unit == UNIT_BOM) push_char(1'b0, 8'h00, 1'b1, last);
				else push_char(1'b1, fold_code(unit), last, last);
			FMT_UTF8: utf8_byte(unit[7:0], last);
			default: push_char(1'b0, 8'h00, 1'b1, last);
			endcase
		endfunction

		task flag_mismatch(string msg);
			errors++;
			if (errors <= 40) $display("%0t: mismatch: %s", $time, msg);
		endtask

		task check_char(logic cv, logic [7:0] ch, logic eon, logic [7:0] len);
			ntdc_res_t want;
			seen++;
			if (due_chars.size() == 0) begin
				flag_mismatch($sformatf("result %0d with no item waiting (char %h, length %0d)",
					seen, ch, len));
				return;
			end
			want = due_chars.pop_front();
			if (cv !== want.char_valid)
				flag_mismatch($sformatf("result %0d char_valid %b, want %b",
					seen, cv, want.char_valid));
			if (ch !== want.out_char)
				flag_mismatch($sformatf("result %0d out_char %h, want %h",
					seen, ch, want.out_char));
			if (eon !== want.end_of_name)
				flag_mismatch($sformatf("result %0d end_of_name %b, want %b",
					seen, eon, want.end_of_name));
			if (len !== want.name_length)
				flag_mismatch($sformatf("result %0d name_length %0d, want %0d",
					seen, len, want.name_length));
		endtask

		task report_leftovers();
			ntdc_res_t want;
			while (due_chars.size() != 0) begin
				want = due_chars.pop_front();
				flag_mismatch($sformatf("no result for expected char %h length %0d",
					want.out_char, want.name_length));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] code_unit = '0;
	logic        last_unit = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        char_valid;
	logic [7:0]  out_char;
	logic        end_of_name;
	logic [7:0]  name_length;

	char_scoreboard sb;
	logic [16:0]    name_q[$];
	logic           quiet = 1'b0;
	logic           long_hold = 1'b0;
	int             budget;

	name_text_to_display_char_top #(
		.NAME_MAX(NAME_MAX_TB)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.code_unit(code_unit),
		.last_unit(last_unit),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.char_valid(char_valid),
		.out_char(out_char),
		.end_of_name(end_of_name),
		.name_length(name_length)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.decode_unit(code_unit, last_unit);
			if (out_valid && !out_stall)
				sb.check_char(char_valid, out_char, end_of_name, name_length);
		end
	end

	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				long_hold = 1'b0;
			end else if (out_valid && !out_stall) begin
				n = quiet ? 0 : $urandom_range(0, 4);
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic send_unit(input logic [15:0] unit, input logic last);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		code_unit <= unit;
		last_unit <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		sb.set_reg(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [1:0] fmt, input logic cyr, input logic [7:0] repl);
		settle();
		write_reg(REG_NAME_FORMAT, {6'd0, fmt});
		write_reg(REG_CYRILLIC_ENABLE, {7'd0, cyr});
		write_reg(REG_REPLACE_CHAR, repl);
	endtask

	function automatic void add_byte(logic [7:0] b);
		name_q.push_back({1'b0, 8'($urandom), b});
	endfunction

	function automatic logic [7:0] cont_byte();
		if ($urandom_range(0, 9) == 0) return 8'($urandom);
		return {2'b10, 6'($urandom)};
	endfunction

	function automatic void add_utf8_char();
		int r;
		int n;
		logic [10:0] cp;
		logic [7:0]  lead;
		r = $urandom_range(0, 99);
		n = 0;
		if (r < 30) begin
			add_byte(8'($urandom_range(1, 127)));
		end else if (r < 60) begin
			cp = 11'($urandom_range(16'h0400, 16'h045F));
			add_byte({3'b110, cp[10:6]});
			add_byte({2'b10, cp[5:0]});
		end else if (r < 94) begin
			if (r < 70) begin lead = {3'b110, 5'($urandom)}; n = 1; end
			else if (r < 80) begin lead = {4'b1110, 4'($urandom)}; n = 2; end
			else if (r < 85) begin lead = {5'b11110, 3'($urandom)}; n = 3; end
			else if (r < 88) begin lead = {6'b111110, 2'($urandom)}; n = 4; end
			else if (r < 91) begin lead = {7'b1111110, 1'($urandom)}; n = 5; end
			else begin lead = {3'b100, 5'($urandom)}; n = 1; end
			add_byte(lead);
			repeat (n) add_byte(cont_byte());
		end else if (r < 97) begin
			add_byte({1'b1, 1'($urandom), 5'b11111, 1'($urandom)});
		end else if (r == 97) begin
			add_byte(8'h00);
		end else begin
			add_byte(8'($urandom));
		end
	endfunction

	function automatic void add_utf16_unit();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) name_q.push_back({1'b0, 16'($urandom_range(0, 16'h00FF))});
		else if (r < 65) name_q.push_back({1'b0, 16'($urandom_range(16'h0400, 16'h045F))});
		else if (r < 75) name_q.push_back({1'b0, 8'($urandom), 8'h00});
		else if (r < 97) name_q.push_back({1'b0, 16'($urandom)});
		else if (r == 97) name_q.push_back({1'b0, 16'h0000});
		else name_q.push_back({1'b0, UNIT_BOM});
	endfunction

	task automatic send_name(input logic [1:0] fmt);
		int len;
		int r;
		name_q.delete();
		len = $urandom_range(1, 10);
		repeat (len) begin
			case (fmt)
			FMT_TEXT8: begin
				r = $urandom_range(0, 99);
				if (r < 60) add_byte(8'($urandom_range(32, 126)));
				else if (r < 97) add_byte(8'($urandom_range(1, 255)));
				else add_byte(8'h00);
			end
			FMT_UTF16: add_utf16_unit();
			FMT_UTF8: add_utf8_char();
			default: name_q.push_back({1'b0, 16'($urandom)});
			endcase
			if (fmt == FMT_RESERVED) break;
		end
		if (fmt == FMT_UTF8 && $urandom_range(0, 9) == 0) begin
			add_byte(8'($urandom_range(8'hC0, 8'hFD)));
			if ($urandom_range(0, 1) == 1) add_byte(cont_byte());
		end
		name_q[name_q.size() - 1][16] = 1'b1;
		foreach (name_q[k]) begin
			if (budget == 0) break;
			send_unit(name_q[k][15:0], name_q[k][16]);
			budget--;
		end
	endtask

	task automatic run_phase(input logic [1:0] fmt, input logic cyr, input logic [7:0] repl,
			input int items, input logic calm, input logic hold);
		set_config(fmt, cyr, repl);
		quiet = calm;
		if (hold) long_hold = 1'b1;
		budget = items;
		while (budget > 0) send_name(fmt);
		quiet = 1'b0;
	endtask

	initial begin
		sb = new(LEN_CAP);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Register defaults after reset: eight-bit text with Cyrillic folding.
		send_unit(16'hFF61, 1'b0);
		send_unit(16'h00C5, 1'b0);
		send_unit(16'h00E3, 1'b0);
		send_unit(16'h00A8, 1'b0);
		send_unit(16'h00B8, 1'b1);
		send_unit(16'h0000, 1'b0);
		send_unit(16'h0041, 1'b1);

		set_config(FMT_UTF16, 1'b1, CHAR_STAR);
		send_unit(16'h0410, 1'b0);
		send_unit(16'h044F, 1'b0);
		send_unit(16'h0401, 1'b0);
		send_unit(16'h6100, 1'b0);
		send_unit(16'h1234, 1'b0);
		send_unit(UNIT_BOM, 1'b1);

		set_config(FMT_UTF8, 1'b1, 8'hFF);
		send_unit(16'h00D0, 1'b0);
		send_unit(16'h0081, 1'b0);
		send_unit(16'h0080, 1'b0);
		send_unit(16'h0000, 1'b0);
		send_unit(16'h00F0, 1'b0);
		send_unit(16'h009F, 1'b0);
		send_unit(16'h0098, 1'b0);
		send_unit(16'h0080, 1'b0);
		send_unit(16'h00E2, 1'b0);
		send_unit(16'h0082, 1'b1);
		send_unit(16'h00FF, 1'b1);

		set_config(FMT_RESERVED, 1'b0, 8'h00);
		send_unit(16'h1234, 1'b1);

		// The receiver holds off in the first phase so the input side backs up.
		run_phase(FMT_UTF8, 1'b1, CHAR_STAR, 130, 1'b0, 1'b1);
		run_phase(FMT_UTF16, 1'b1, 8'hFF, 130, 1'b0, 1'b0);
		run_phase(FMT_TEXT8, 1'b0, 8'h00, 120, 1'b0, 1'b0);
		run_phase(FMT_UTF8, 1'b0, 8'($urandom), 130, 1'b0, 1'b0);
		run_phase(FMT_RESERVED, 1'b1, CHAR_DASH, 40, 1'b0, 1'b0);
		run_phase(FMT_UTF16, 1'b0, 8'h00, 120, 1'b1, 1'b0);
		run_phase(FMT_UTF8, 1'b1, 8'hFF, 130, 1'b1, 1'b0);
		run_phase(FMT_TEXT8, 1'b1, 8'($urandom), 120, 1'b0, 1'b0);
		run_phase(FMT_UTF8, 1'($urandom), CHAR_DASH, 130, 1'b0, 1'b0);
		run_phase(FMT_UTF16, 1'($urandom), 8'($urandom), 130, 1'b0, 1'b0);

		// One name long enough to saturate the length counter.
		set_config(FMT_TEXT8, 1'b1, CHAR_DASH);
		repeat (299) send_unit({8'($urandom), 8'($urandom_range(32, 126))}, 1'b0);
		send_unit(16'h0041, 1'b1);

		settle();
		sb.report_leftovers();
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
